// ===== hw/rtl/assert_macros.svh =====
// Shared assertion macros, clocked on the rising edge, disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/mcog_pkg.sv =====
package mcog_pkg;

	localparam int DIM_BITS   = 15;
	localparam int CNT_BITS   = 4;
	localparam int FMT_BITS   = 8;
	localparam int BYTES_BITS = 31;
	localparam int TOTAL_BITS = 32;
	localparam int PROD_BITS  = 2 * DIM_BITS;

	localparam logic [BYTES_BITS-1:0] BYTES_SAT = '1;
	localparam logic [TOTAL_BITS-1:0] TOTAL_SAT = '1;

	localparam logic [FMT_BITS-1:0] FMT_BC1_LO   = 8'd70;
	localparam logic [FMT_BITS-1:0] FMT_BC1_HI   = 8'd72;
	localparam logic [FMT_BITS-1:0] FMT_RGBA8_LO = 8'd27;
	localparam logic [FMT_BITS-1:0] FMT_RGBA8_HI = 8'd32;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_BC1,
		KIND_RGBA8
	} fmt_kind_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_UNSUP    = 2'd1,
		STAT_MISMATCH = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic last;
		logic slot_free;
	} dp_sts_t;

	function automatic fmt_kind_t fmt_kind(input logic [FMT_BITS-1:0] code);
		fmt_kind_t k;
		case (code) inside
			[FMT_BC1_LO:FMT_BC1_HI]:     k = KIND_BC1;
			[FMT_RGBA8_LO:FMT_RGBA8_HI]: k = KIND_RGBA8;
			default:                     k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/mcog_ctrl.sv =====
module mcog_ctrl import mcog_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_EMIT;
			end
			S_EMIT: begin
				// wait for the output register to drain
				if (sts.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.last ? S_IDLE : S_CALC;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/mcog_dp.sv =====
module mcog_dp import mcog_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic [FMT_BITS-1:0]   in_format,
	input  logic [DIM_BITS-1:0]   in_height,
	input  logic [DIM_BITS-1:0]   in_width,
	input  logic [CNT_BITS-1:0]   in_count,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [CNT_BITS-1:0]   out_index,
	output logic [TOTAL_BITS-1:0] out_offset,
	output logic [BYTES_BITS-1:0] out_bytes,
	output logic [TOTAL_BITS-1:0] out_total,
	output logic                  out_last,
	output status_t               out_status
);

	fmt_kind_t             kind_q;
	logic [DIM_BITS-1:0]   h_q, w_q;
	logic [CNT_BITS-1:0]   count_q, idx_q;
	logic [TOTAL_BITS-1:0] total_q;

	logic [BYTES_BITS-1:0] bytes_s1;
	logic                  last_s1;
	status_t               status_s1;

	logic                  o_valid_q;
	logic [CNT_BITS-1:0]   o_idx_q;
	logic [TOTAL_BITS-1:0] o_off_q, o_total_q;
	logic [BYTES_BITS-1:0] o_bytes_q;
	logic                  o_last_q;
	status_t               o_status_q;

	logic [DIM_BITS-1:0]   h_blk, w_blk, op_a, op_b, h_half, w_half;
	logic [PROD_BITS-1:0]  prod;
	logic [TOTAL_BITS:0]   size_c;
	logic [BYTES_BITS-1:0] bytes_c;
	logic                  nat_end, cnt_end, last_c;
	status_t               status_c;
	logic [TOTAL_BITS:0]   sum_c;
	logic [TOTAL_BITS-1:0] total_c;

	always_comb begin
		// BC1 works on 4x4 blocks, at least one each way
		h_blk = (h_q >> 2) == '0 ? DIM_BITS'(1) : (h_q >> 2);
		w_blk = (w_q >> 2) == '0 ? DIM_BITS'(1) : (w_q >> 2);
		op_a  = (kind_q == KIND_BC1) ? h_blk : h_q;
		op_b  = (kind_q == KIND_BC1) ? w_blk : w_q;
		prod  = op_a * op_b;
		case (kind_q)
			KIND_BC1:   size_c = (TOTAL_BITS+1)'({prod, 3'b000});
			KIND_RGBA8: size_c = (TOTAL_BITS+1)'({prod, 2'b00});
			default:    size_c = '0;
		endcase
		bytes_c = (size_c > (TOTAL_BITS+1)'(BYTES_SAT)) ? BYTES_SAT
			: size_c[BYTES_BITS-1:0];

		nat_end = (h_q == DIM_BITS'(1)) && (w_q == DIM_BITS'(1));
		cnt_end = ({1'b0, idx_q} + (CNT_BITS+1)'(1)) == {1'b0, count_q};
		last_c  = (kind_q == KIND_NONE) || (count_q == '0) || nat_end || cnt_end;
		// a declared count of one matches a chain cut at the top level
		if (kind_q == KIND_NONE) begin
			status_c = STAT_UNSUP;
		end else if (last_c && !(cnt_end && (nat_end || count_q == CNT_BITS'(1)))) begin
			status_c = STAT_MISMATCH;
		end else begin
			status_c = STAT_OK;
		end

		h_half = (h_q >> 1) == '0 ? DIM_BITS'(1) : (h_q >> 1);
		w_half = (w_q >> 1) == '0 ? DIM_BITS'(1) : (w_q >> 1);

		sum_c   = {1'b0, total_q} + (TOTAL_BITS+1)'(bytes_s1);
		total_c = sum_c[TOTAL_BITS] ? TOTAL_SAT : sum_c[TOTAL_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= fmt_kind(in_format);
			h_q     <= in_height;
			w_q     <= in_width;
			count_q <= in_count;
			idx_q   <= '0;
			total_q <= '0;
		end else if (cmd.calc) begin
			h_q <= h_half;
			w_q <= w_half;
		end else if (cmd.emit) begin
			idx_q   <= idx_q + CNT_BITS'(1);
			total_q <= total_c;
		end
		if (cmd.calc) begin
			bytes_s1  <= bytes_c;
			last_s1   <= last_c;
			status_s1 <= status_c;
		end
		if (cmd.emit) begin
			o_idx_q    <= idx_q;
			o_off_q    <= total_q;
			o_bytes_q  <= bytes_s1;
			o_total_q  <= total_c;
			o_last_q   <= last_s1;
			o_status_q <= status_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			o_valid_q <= 1'b1;
		end else if (out_ready) begin
			o_valid_q <= 1'b0;
		end
	end

	assign sts.last      = last_s1;
	assign sts.slot_free = !o_valid_q || out_ready;

	assign out_valid  = o_valid_q;
	assign out_index  = o_idx_q;
	assign out_offset = o_off_q;
	assign out_bytes  = o_bytes_q;
	assign out_total  = o_total_q;
	assign out_last   = o_last_q;
	assign out_status = o_status_q;

endmodule

// ===== hw/rtl/mip_chain_offset_generator.sv =====
// The descriptor is registered on acceptance, each level size in S_CALC (multiply),
// and the output in S_EMIT (accumulate); S_EMIT waits while a stalled sink holds the
// output. The size multiplier and running-total adder are shared by all levels, and
// a new descriptor is accepted only after the last level of the chain is emitted.
// Reset (arst_n low) clears the controller and the output valid; nothing is pending.
module mip_chain_offset_generator import mcog_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// format_code[7:0], image_height[22:8], image_width[37:23], level_count[41:38], zero
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// level_index[3:0], level_offset[35:4], level_bytes[66:36], running_total[98:67], zero
	output logic [103:0] m_axis_tdata,
	output logic         m_axis_tlast,
	// status[1:0]
	output logic [1:0]   m_axis_tuser
);

	dp_cmd_t               cmd;
	dp_sts_t               sts;
	logic [CNT_BITS-1:0]   out_index;
	logic [TOTAL_BITS-1:0] out_offset, out_total;
	logic [BYTES_BITS-1:0] out_bytes;
	status_t               out_status;

	mcog_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcog_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_format  (s_axis_tdata[7:0]),
		.in_height  (s_axis_tdata[22:8]),
		.in_width   (s_axis_tdata[37:23]),
		.in_count   (s_axis_tdata[41:38]),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_index  (out_index),
		.out_offset (out_offset),
		.out_bytes  (out_bytes),
		.out_total  (out_total),
		.out_last   (m_axis_tlast),
		.out_status (out_status)
	);

	assign m_axis_tdata = {5'b00000, out_total, out_bytes, out_offset, out_index};
	assign m_axis_tuser = out_status;

endmodule

// ===== hw/rtl/mcog_checker.sv =====
`include "assert_macros.svh"

module mcog_checker import mcog_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [103:0] m_axis_tdata,
	input logic         m_axis_tlast,
	input logic [1:0]   m_axis_tuser
);

	logic stalled;
	logic ok_code;
	logic flagged;
	logic total_ok;
	logic in_xfer;

	assign stalled  = m_axis_tvalid && !m_axis_tready;
	assign ok_code  = (m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_UNSUP)
		|| (m_axis_tuser == STAT_MISMATCH);
	assign flagged  = m_axis_tvalid && (m_axis_tuser != STAT_OK);
	assign total_ok = m_axis_tdata[98:67] >= m_axis_tdata[35:4];
	assign in_xfer  = s_axis_tvalid && s_axis_tready;

	`ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_IMPLY(a_err_last, clk, arst_n, flagged, m_axis_tlast)
	`ASSERT_IMPLY(a_code, clk, arst_n, m_axis_tvalid, ok_code)
	`ASSERT_IMPLY(a_total_ge_off, clk, arst_n, m_axis_tvalid, total_ok)
	`ASSERT_NEXT(a_busy_after_in, clk, arst_n, in_xfer, !s_axis_tready)

endmodule

bind mip_chain_offset_generator mcog_checker u_mcog_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
